[design/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the worker pool dispatcher.
// ----------------------------------------------------------------------------
package wpd_pkg;

    localparam int NUM_WORKERS = 8;
    localparam int NUM_PROCS   = 256;

    localparam int W_W    = $clog2(NUM_WORKERS);      // worker index
    localparam int P_W    = $clog2(NUM_PROCS);        // process index
    localparam int CNT_W  = $clog2(NUM_WORKERS + 1);  // free worker count
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;

    // pending search: groups of PGRP processes, one OR summary per group
    localparam int PGRP     = 16;
    localparam int J_W      = $clog2(PGRP);
    localparam int NUM_PGRP = (NUM_PROCS + PGRP - 1) / PGRP;
    localparam int G_W      = (NUM_PGRP > 1) ? $clog2(NUM_PGRP) : 1;
    localparam int PI_W     = G_W + J_W;
    localparam int PEND_N   = NUM_PGRP * PGRP;

    // stream payload layout
    localparam int IN_USER_W  = CMD_W + 1;
    localparam int IN_USED_W  = 8 + 3 + 1;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W = ST_W + 1 + 3 + 8 + 1 + 1 + 4;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 3'd0,
        ST_TWO_CALLS    = 3'd1,
        ST_TWO_DEFERRED = 3'd2,
        ST_STALE        = 3'd3,
        ST_NOT_BUSY     = 3'd4
    } status_t;

    typedef struct packed {
        logic normal_work;
        logic deferred_work;
        logic active;
    } proc_flags_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic rd_req;
        logic eval;
        logic fin;
        logic grp;
        logic sel;
        logic rd_pend;
        logic handover;
        logic load_out;
    } wpd_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic fin_ok;
        logic any_pending;
        logic out_free;
    } wpd_stat_t;

endpackage

[design/wpd_ctrl.sv]
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer: steps one transaction through decode, table access, pending
// search and result hand-off.
// ----------------------------------------------------------------------------
module wpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wpd_pkg::wpd_stat_t stat,
    output wpd_pkg::wpd_ctrl_t ctrl
);
    import wpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_EVAL,
        S_FIN,
        S_GRP,
        S_SEL,
        S_PRD,
        S_BIND,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                // read of the process entry is harmless for other commands
                ctrl.rd_req = 1'b1;
                unique case (stat.cmd)
                    CMD_START, CMD_QUERY: state_next = S_EVAL;
                    CMD_FINISH:           state_next = S_FIN;
                    default:              state_next = S_OUT;
                endcase
            end
            S_EVAL:
            begin
                ctrl.eval  = 1'b1;
                state_next = S_OUT;
            end
            S_FIN:
            begin
                ctrl.fin   = 1'b1;
                state_next = stat.fin_ok ? S_GRP : S_OUT;
            end
            S_GRP:
            begin
                ctrl.grp   = 1'b1;
                state_next = stat.any_pending ? S_SEL : S_OUT;
            end
            S_SEL:
            begin
                ctrl.sel   = 1'b1;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                ctrl.rd_pend = 1'b1;
                state_next   = S_BIND;
            end
            S_BIND:
            begin
                ctrl.handover = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s_tready  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s_tready  <= (state_next == S_IDLE);
        end
    end

endmodule

[design/wpd_dp.sv]
// ----------------------------------------------------------------------------
// wpd_dp
// Datapath: request registers, per-process flag memory with valid bits,
// pending table with group search, worker table and result register.
// ----------------------------------------------------------------------------
module wpd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [wpd_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic [wpd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wpd_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wpd_pkg::wpd_ctrl_t                ctrl,
    output wpd_pkg::wpd_stat_t                stat
);
    import wpd_pkg::*;

    // request
    cmd_t             req_cmd_reg;
    logic [P_W-1:0]   req_p_reg;
    logic [W_W-1:0]   req_w_reg;
    logic             req_pm_reg;
    logic             req_spare_reg;

    // per-process flags
    proc_flags_t      pmem [NUM_PROCS];
    logic [NUM_PROCS-1:0] vld_reg;
    proc_flags_t      rd_reg;
    logic             rd_vld_reg;
    logic [P_W-1:0]   rd_addr;
    logic             wr_en;
    logic [P_W-1:0]   wr_addr;
    proc_flags_t      wr_data;
    proc_flags_t      flags_rd;

    // pending table
    logic [PEND_N-1:0]   pend_reg;
    logic [NUM_PGRP-1:0] grp_any;
    logic [G_W-1:0]      grp_first;
    logic [G_W-1:0]      grp_reg;
    logic [PGRP-1:0]     grp_slice;
    logic [J_W-1:0]      slot_first;
    logic [P_W-1:0]      pend_idx_reg;
    logic                pend_p;

    // workers
    logic [NUM_WORKERS-1:0] busy_reg;
    logic [P_W-1:0]   wproc_reg [NUM_WORKERS];
    logic [CNT_W-1:0] free_cnt;
    logic [W_W-1:0]   first_free;
    logic             fin_ok;
    logic [P_W-1:0]   fin_proc;

    // start / query evaluation
    logic             proc_idle;
    status_t          st_start;
    logic             start_ok;
    logic             start_bind;
    logic             query_cs;

    // result
    status_t          res_status_reg;
    logic             res_assigned_reg;
    logic [W_W-1:0]   res_sw_reg;
    logic [P_W-1:0]   res_sp_reg;
    logic             res_queued_reg;
    logic             res_cs_reg;
    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // ---------------------------------------------------------------- workers
    always_comb
    begin
        free_cnt   = CNT_W'($countones(~busy_reg));
        first_free = '0;
        for (int i = NUM_WORKERS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
                first_free = W_W'(i);
        end
    end

    assign fin_ok   = (int'(req_w_reg) < NUM_WORKERS) && busy_reg[req_w_reg];
    assign fin_proc = wproc_reg[req_w_reg];

    // ------------------------------------------------------- start and query
    assign flags_rd  = rd_vld_reg ? rd_reg : proc_flags_t'('0);
    assign pend_p    = pend_reg[PI_W'(req_p_reg)];
    assign proc_idle = !pend_p && !flags_rd.active;

    always_comb
    begin
        st_start = ST_OK;
        if (!proc_idle)
        begin
            priority if (!req_pm_reg && flags_rd.normal_work)
                st_start = ST_TWO_CALLS;
            else if (req_pm_reg && flags_rd.deferred_work)
                st_start = ST_TWO_DEFERRED;
            else
                st_start = ST_OK;
        end
        else if (flags_rd.normal_work || flags_rd.deferred_work)
        begin
            st_start = ST_STALE;
        end
    end

    assign start_ok   = (st_start == ST_OK);
    // keep one worker spare unless the caller may take the last one
    assign start_bind = proc_idle &&
                        (free_cnt >= (req_spare_reg ? CNT_W'(1) : CNT_W'(2)));
    assign query_cs   = proc_idle ? 1'b1 : (flags_rd.normal_work ? 1'b0 : pend_p);

    // ---------------------------------------------------------- pending search
    always_comb
    begin
        grp_first = '0;
        for (int g = NUM_PGRP - 1; g >= 0; g--)
        begin
            grp_any[g] = |pend_reg[g*PGRP +: PGRP];
            if (grp_any[g])
                grp_first = G_W'(g);
        end
    end

    assign grp_slice = pend_reg[{grp_reg, {J_W{1'b0}}} +: PGRP];

    always_comb
    begin
        slot_first = '0;
        for (int j = PGRP - 1; j >= 0; j--)
        begin
            if (grp_slice[j])
                slot_first = J_W'(j);
        end
    end

    // ------------------------------------------------------------ flag memory
    assign rd_addr = ctrl.rd_pend ? pend_idx_reg : req_p_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req_p_reg;
        wr_data = flags_rd;
        if (ctrl.eval && (req_cmd_reg == CMD_START) && start_ok)
        begin
            wr_en = 1'b1;
            if (req_pm_reg)
                wr_data.deferred_work = 1'b1;
            else
                wr_data.normal_work = 1'b1;
            if (start_bind)
                wr_data.active = 1'b1;
        end
        else if (ctrl.fin && fin_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = fin_proc;
            wr_data = '0;
        end
        else if (ctrl.handover)
        begin
            wr_en          = 1'b1;
            wr_addr        = pend_idx_reg;
            wr_data.active = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pmem[wr_addr] <= wr_data;
        if (ctrl.rd_req || ctrl.rd_pend)
            rd_reg <= pmem[rd_addr];
    end

    // ------------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            pend_reg      <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (ctrl.rd_req || ctrl.rd_pend)
                rd_vld_reg <= vld_reg[rd_addr];

            if (ctrl.eval && (req_cmd_reg == CMD_START) && start_ok && proc_idle)
            begin
                if (start_bind)
                    busy_reg[first_free] <= 1'b1;
                else
                    pend_reg[PI_W'(req_p_reg)] <= 1'b1;
            end
            if (ctrl.fin && fin_ok)
                busy_reg[req_w_reg] <= 1'b0;
            if (ctrl.handover)
            begin
                busy_reg[req_w_reg]           <= 1'b1;
                pend_reg[PI_W'(pend_idx_reg)] <= 1'b0;
            end

            if (ctrl.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_cmd_reg      <= cmd_t'(s_tuser[CMD_W-1:0]);
            req_pm_reg       <= s_tuser[CMD_W];
            req_p_reg        <= s_tdata[P_W-1:0];
            req_w_reg        <= s_tdata[8 +: W_W];
            req_spare_reg    <= s_tdata[11];
            res_status_reg   <= ST_OK;
            res_assigned_reg <= 1'b0;
            res_sw_reg       <= '0;
            res_sp_reg       <= '0;
            res_queued_reg   <= 1'b0;
            res_cs_reg       <= 1'b0;
        end

        if (ctrl.eval)
        begin
            if (req_cmd_reg == CMD_START)
            begin
                res_status_reg <= st_start;
                if (start_ok && proc_idle)
                begin
                    if (start_bind)
                    begin
                        res_assigned_reg      <= 1'b1;
                        res_sw_reg            <= first_free;
                        res_sp_reg            <= req_p_reg;
                        wproc_reg[first_free] <= req_p_reg;
                    end
                    else
                    begin
                        res_queued_reg <= 1'b1;
                    end
                end
            end
            else
            begin
                res_cs_reg <= query_cs;
            end
        end

        if (ctrl.fin && !fin_ok)
            res_status_reg <= ST_NOT_BUSY;

        if (ctrl.grp)
            grp_reg <= grp_first;
        if (ctrl.sel)
            pend_idx_reg <= P_W'({grp_reg, slot_first});

        if (ctrl.handover)
        begin
            res_assigned_reg     <= 1'b1;
            res_sw_reg           <= req_w_reg;
            res_sp_reg           <= pend_idx_reg;
            wproc_reg[req_w_reg] <= pend_idx_reg;
        end

        if (ctrl.load_out)
        begin
            out_data_reg <= OUT_DATA_W'({free_cnt, res_cs_reg, res_queued_reg,
                                         res_sp_reg, res_sw_reg, res_assigned_reg,
                                         res_status_reg});
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign stat.cmd         = req_cmd_reg;
    assign stat.fin_ok      = fin_ok;
    assign stat.any_pending = |grp_any;
    assign stat.out_free    = !out_valid_reg || m_tready;

endmodule

[design/worker_pool_dispatcher_unit.sv]
// ----------------------------------------------------------------------------
// worker_pool_dispatcher_unit
// Binds client-process jobs to a pool of workers, keeping one worker spare unless the caller may take the last one.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. START and QUERY go through decode,
// a read of the process entry and evaluation; FINISH of a busy worker clears
// its process entry and, when a process is pending, hands it to the freed
// worker. The time taken by FINISH is set by the read-modify-write of the
// per-process flag memory and by the two-level search of the pending table
// (lowest group, then lowest process inside that group). The result
// register frees the input side while a result waits to be taken. Reset is
// immediate: per-process entries carry valid bits, so there is no clearing
// pass.
module worker_pool_dispatcher_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[1:0], deferred[2]
    input  logic [wpd_pkg::IN_USER_W-1:0]   s_tuser,
    // process_index[7:0], worker_index[10:8], take_last[11], zero[15:12]
    input  logic [wpd_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], assigned[3], served_worker[6:4], served_process[14:7],
    // queued[15], can_start[16], free_workers[20:17], zero[23:21]
    output logic [wpd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import wpd_pkg::*;

    wpd_ctrl_t ctrl;
    wpd_stat_t stat;

    wpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    wpd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctrl     (ctrl),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:17] <= CNT_W'(NUM_WORKERS)))
        else $error("free worker count out of range");

    a_bind_or_queue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[15]))
        else $error("process both bound and queued");

    a_error_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> !m_tdata[3] && !m_tdata[15])
        else $error("error status with a binding or queueing");
`endif

endmodule
